[rtl/dvl_pkg.sv]
package dvl_pkg;

    // table and arithmetic sizing
    localparam int MAX_LIGHTS = 7;
    localparam int FRAC_BITS  = 14;
    localparam int NUM_CELLS  = MAX_LIGHTS + 1;
    localparam int IDX_W      = 3;
    localparam int COL_W      = 8;
    localparam int VEC_W      = 16;
    localparam int PROD_W     = 2 * VEC_W;
    localparam int DOT_W      = PROD_W + 2;
    // a positive dot product stays below 2**PROD_W; ambient needs 1.0 in the same format
    localparam int INTEN_W    = (PROD_W - FRAC_BITS > FRAC_BITS + 1) ?
                                (PROD_W - FRAC_BITS) : (FRAC_BITS + 1);
    localparam int ACC_W      = COL_W + FRAC_BITS;
    localparam int SUM_W      = COL_W + INTEN_W + 1;

    localparam logic [ACC_W-1:0]   ACC_LIMIT = ACC_W'((2 ** COL_W - 1) * (2 ** FRAC_BITS));
    localparam logic [INTEN_W-1:0] AMB_INTEN = INTEN_W'(1) << FRAC_BITS;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // register port
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int DATA_W    = 32;
    localparam logic [REG_IDX_W-1:0] REG_LIT_COUNT = '0;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        light_index;
        logic [COL_W-1:0]        color_r;
        logic [COL_W-1:0]        color_g;
        logic [COL_W-1:0]        color_b;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0] out_r;
        logic [COL_W-1:0] out_g;
        logic [COL_W-1:0] out_b;
    } result_t;

    // beat handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic                      shade;
        logic [IDX_W-1:0]          idx;
        logic [2:0][COL_W-1:0]     col;
        logic [2:0][VEC_W-1:0]     vec;
        logic [2:0][ACC_W-1:0]     acc;
    } beat_t;

endpackage

[rtl/dvl_cell.sv]
module dvl_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [dvl_pkg::IDX_W-1:0] cell_id,
    input  logic [dvl_pkg::IDX_W-1:0] lights,
    input  dvl_pkg::beat_t        beat_in,
    output dvl_pkg::beat_t        beat_out
);
    import dvl_pkg::*;

    // table entry held by this cell
    logic [2:0][COL_W-1:0] col_reg;
    logic [2:0][VEC_W-1:0] dir_reg;

    // stage registers
    beat_t                    s1_beat_reg, s2_beat_reg, s3_beat_reg;
    beat_t                    s3_next;
    logic [2:0][COL_W-1:0]    s1_col_reg, s2_col_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic [INTEN_W-1:0]       s2_inten_reg, inten_next;
    logic [2:0][ACC_W-1:0]    acc_next;

    logic                     wr_hit;
    logic                     is_light;
    logic                     is_amb;
    logic signed [DOT_W-1:0]  dot;
    logic                     dot_pos;
    logic [SUM_W-1:0]         sum [3];

    // write beat lands in this cell when its index matches
    assign wr_hit = beat_in.valid && !beat_in.shade && (beat_in.idx == cell_id);

    always_ff @(posedge clk)
    begin
        if (adv && wr_hit)
        begin
            col_reg <= beat_in.col;
            dir_reg <= beat_in.vec;
        end
    end

    // stage 1: component products against this light direction
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = PROD_W'($signed(dir_reg[c]) * $signed(beat_in.vec[c]));
        end
    end

    // role of this cell for the current light count
    assign is_light = (cell_id < lights);
    assign is_amb   = (cell_id == lights);

    // stage 2: dot product and clamped intensity
    assign dot = DOT_W'(s1_prod_reg[0]) + DOT_W'(s1_prod_reg[1]) + DOT_W'(s1_prod_reg[2]);
    assign dot_pos = !dot[DOT_W-1] && (dot != '0);

    always_comb
    begin
        if (is_amb)
        begin
            inten_next = AMB_INTEN;
        end
        else if (is_light && dot_pos)
        begin
            inten_next = INTEN_W'(dot[PROD_W-1:FRAC_BITS]);
        end
        else
        begin
            inten_next = '0;
        end
    end

    // stage 3: color times intensity, saturating add; idle cells pass the sum on
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = SUM_W'(s2_beat_reg.acc[c])
                   + SUM_W'(s2_col_reg[c]) * SUM_W'(s2_inten_reg);
            if (!s2_beat_reg.shade || (s2_inten_reg == '0))
            begin
                acc_next[c] = s2_beat_reg.acc[c];
            end
            else if (sum[c] > SUM_W'(ACC_LIMIT))
            begin
                acc_next[c] = ACC_LIMIT;
            end
            else
            begin
                acc_next[c] = sum[c][ACC_W-1:0];
            end
        end
    end

    // beat leaving stage 3 carries the new sums
    always_comb
    begin
        s3_next     = s2_beat_reg;
        s3_next.acc = acc_next;
    end

    // beat flow through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_beat_reg <= '0;
            s2_beat_reg <= '0;
            s3_beat_reg <= '0;
        end
        else if (adv)
        begin
            s1_beat_reg <= beat_in;
            s2_beat_reg <= s1_beat_reg;
            s3_beat_reg <= s3_next;
        end
    end

    // datapath registers along the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg   <= col_reg;
            s1_prod_reg  <= prod_next;
            s2_col_reg   <= s1_col_reg;
            s2_inten_reg <= inten_next;
        end
    end

    assign beat_out = s3_beat_reg;

endmodule

[rtl/directional_vertex_lighting_top.sv]
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   item (write entry or shade normal)
// result    out        result_valid / result_stall  result (shaded rgb)
// config    in         psel / penable / pwrite   light count at byte 0
//
// eight cells in a row, one per table entry, three stages each; a beat moves
// one stage per cycle while no result is held, so one item per cycle
// write beats travel the row in order and land in their cell, giving no result
// a stalled result freezes the whole row and holds item_stall high
// reset clears the light count and the beat valid bits; table entries stay unset
module directional_vertex_lighting_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  dvl_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output dvl_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dvl_pkg::ADDR_W-1:0]     paddr,
    input  logic [dvl_pkg::DATA_W-1:0]     pwdata,
    output logic [dvl_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import dvl_pkg::*;

    logic [IDX_W-1:0] lit_count_reg;
    logic [IDX_W-1:0] lights;
    logic             adv;
    beat_t            chain [NUM_CELLS+1];
    logic             result_valid_reg;
    result_t          result_reg;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_LIT_COUNT))
        begin
            lit_count_reg <= pwdata[IDX_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_LIT_COUNT: prdata = DATA_W'(lit_count_reg);
            default:       prdata = '0;
        endcase
    end

    // light count capped at MAX_LIGHTS
    assign lights = (lit_count_reg > IDX_W'(MAX_LIGHTS)) ? IDX_W'(MAX_LIGHTS) : lit_count_reg;

    // whole row advances unless a result is held
    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    // beat entering the row
    always_comb
    begin
        chain[0].valid  = item_valid;
        chain[0].shade  = (item.cmd == CMD_SHADE);
        chain[0].idx    = item.light_index;
        chain[0].col[0] = item.color_r;
        chain[0].col[1] = item.color_g;
        chain[0].col[2] = item.color_b;
        chain[0].vec[0] = item.vec_x;
        chain[0].vec[1] = item.vec_y;
        chain[0].vec[2] = item.vec_z;
        chain[0].acc    = '0;
    end

    // row of cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        dvl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_id  (IDX_W'(i)),
            .lights   (lights),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= chain[NUM_CELLS].valid && chain[NUM_CELLS].shade;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.out_r <= chain[NUM_CELLS].acc[0][ACC_W-1:FRAC_BITS];
            result_reg.out_g <= chain[NUM_CELLS].acc[1][ACC_W-1:FRAC_BITS];
            result_reg.out_b <= chain[NUM_CELLS].acc[2][ACC_W-1:FRAC_BITS];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // row frozen while the result is held
    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain[NUM_CELLS]))
        else $error("row moved during a stall");

    // accumulators never pass the saturation limit
    a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_CELLS].valid && chain[NUM_CELLS].shade |->
            (chain[NUM_CELLS].acc[0] <= ACC_LIMIT) &&
            (chain[NUM_CELLS].acc[1] <= ACC_LIMIT) &&
            (chain[NUM_CELLS].acc[2] <= ACC_LIMIT))
        else $error("accumulator above saturation limit");

    // a write beat leaving the row produces no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && chain[NUM_CELLS].valid && !chain[NUM_CELLS].shade |=> !result_valid)
        else $error("write beat produced a result");

endmodule
